@@ rtl/core/plane_pair_sphere_intersect_top_macros.svh @@
// Assertion macros for the plane pair / unit sphere intersection block
`ifndef PLANE_PAIR_SPHERE_INTERSECT_TOP_MACROS_SVH
`define PLANE_PAIR_SPHERE_INTERSECT_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked out of reset
`define PPS_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pps check failed");
// next-cycle implication, checked out of reset
`define PPS_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pps check failed");
`else
`define PPS_CHECK_NOW(lbl, ante, cons)
`define PPS_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/pps_pkg.sv @@
// Shared types, constants and saturation helpers for the plane pair sphere block
package pps_pkg;

    localparam int FRAC      = 30;          // fraction bits of all fixed point values
    localparam int NORM_BITS = 30;          // cross magnitudes are scaled below 2^30
    localparam int ISQ_STEPS = 32;          // result bits of the length square root
    localparam int SQ_STEPS  = 31;          // result bits of the discriminant root
    localparam int DIV_W     = 96;          // divider remainder width
    localparam int DIV_BITS  = 32;          // quotient bits produced by the divider
    localparam int DIV_LAT   = DIV_BITS + 3;
    localparam int PIPE_LAT  = 8 + ISQ_STEPS + DIV_LAT + 1 + DIV_LAT + 6 + SQ_STEPS + 3;

    typedef logic signed [31:0] t_fix;
    typedef logic signed [63:0] t_wide;

    localparam t_fix FIX_MAX = 32'sh7fff_ffff;
    localparam t_fix FIX_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_fix first_normal_x;
        t_fix first_normal_y;
        t_fix first_normal_z;
        t_fix first_offset;
        t_fix second_normal_x;
        t_fix second_normal_y;
        t_fix second_normal_z;
        t_fix second_offset;
    } t_in;

    typedef struct packed {
        logic found;
        t_fix first_x;
        t_fix first_y;
        t_fix first_z;
        t_fix second_x;
        t_fix second_y;
        t_fix second_z;
    } t_out;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } t_axis;

    // 2x2 system terms for every axis choice
    typedef struct packed {
        t_wide num_a;   // d1*c2 - d2*c1
        t_wide num_b;   // b1*d2 - b2*d1
        t_wide num_c;   // a1*d2 - a2*d1
        t_wide num_d;   // d1*b2 - d2*b1
        t_wide den_x;
        t_wide den_y;
        t_wide den_z;
    } t_sys;

    // one step of the restoring divider
    typedef struct packed {
        logic [DIV_W-1:0]    rem;
        logic [63:0]         ud;
        logic [DIV_BITS-1:0] q;
        logic                neg;
        logic                dz;
        logic                nz;
        logic                npos;
        logic                ovf;
    } t_div_st;

    // clamp to 32 bits signed
    function automatic t_fix sat32(input logic signed [67:0] v);
        if (v > 68'sd2147483647) return FIX_MAX;
        if (v < -68'sd2147483648) return FIX_MIN;
        return v[31:0];
    endfunction

    // 64-bit add with clamp
    function automatic t_wide sat_add64(input t_wide a, input t_wide b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

endpackage

@@ rtl/core/plane_pair_sphere_intersect_top.sv @@
// Top level: line of two planes against the unit sphere, fully pipelined
//
// Each item carries two planes (normal and offset, Q2.30). The result gives
// the two points where the planes' common line pierces the unit sphere, or
// found = 0 with zeroed points for parallel planes or a line that misses or
// grazes the sphere. One item can enter every cycle while the pipeline is not
// frozen by backpressure; the pipeline has 151 stages plus the output
// register. Most of that depth is the two 35-stage dividers (unit direction,
// then start point) and the two bit-per-stage square roots (32 stages for
// the direction length, 31 for the discriminant). Backpressure freezes the
// pipeline only when the last stage and the output register both hold items
// and the receiver is stalling.
`include "plane_pair_sphere_intersect_top_macros.svh"
module plane_pair_sphere_intersect_top
    import pps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    localparam int LA_LEN  = 5 + ISQ_STEPS + DIV_LAT;   // stages 4 .. 75
    localparam int LSV_LEN = 3 + ISQ_STEPS;             // stages 6 .. 40
    localparam int LB_LEN  = 1 + DIV_LAT;               // stages 76 .. 111
    localparam int LC_LEN  = 6 + SQ_STEPS + 2;          // stages 112 .. 150
    localparam int LH_LEN  = 3 + SQ_STEPS;              // stages 115 .. 148

    typedef logic signed [30:0] t_sv;

    typedef struct packed {
        t_sys sys;
        logic nz;
    } t_ctx_a;

    typedef struct packed {
        t_fix  ux;
        t_fix  uy;
        t_fix  uz;
        t_axis axis;
        logic  nz;
    } t_ctx_b;

    typedef struct packed {
        t_fix px;
        t_fix py;
        t_fix pz;
        t_fix ux;
        t_fix uy;
        t_fix uz;
        logic nz;
    } t_ctx_c;

    // flow control
    logic [PIPE_LAT-1:0] r_vld;
    logic                r_out_vld;
    t_out                r_out;
    logic                en, load;

    assign en      = !(r_vld[PIPE_LAT-1] && r_out_vld && i_stall);
    assign load    = en && r_vld[PIPE_LAT-1];
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (en) r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
            r_out_vld <= load || (r_out_vld && i_stall);
        end
    end

    // ---------------- front: cross product and 2x2 terms ----------------
    t_in    r1_in;
    t_wide  n2_p [0:13];
    t_wide  r2_p [0:13];
    t_wide  r3_cr [0:2];
    t_sys   r3_sys;
    logic [63:0] r4_m [0:2];
    logic        r4_neg [0:2];
    t_ctx_a r_la [0:LA_LEN-1];
    logic [63:0] n5_or;
    logic [6:0]  n5_bl;
    logic [5:0]  n5_k, r5_k;
    logic [63:0] r5_m [0:2];
    logic        r5_neg [0:2];
    logic [29:0] n6_mm [0:2];
    logic [29:0] r6_mm [0:2];
    t_sv    r_lsv [0:LSV_LEN-1][0:2];
    logic [59:0] r7_sq [0:2];

    // the 32x32 products of the two planes needed for the cross product and 2x2 terms
    always_comb begin
        n2_p[0]  = 64'(r1_in.first_normal_y)  * 64'(r1_in.second_normal_z);
        n2_p[1]  = 64'(r1_in.first_normal_z)  * 64'(r1_in.second_normal_y);
        n2_p[2]  = 64'(r1_in.first_normal_z)  * 64'(r1_in.second_normal_x);
        n2_p[3]  = 64'(r1_in.first_normal_x)  * 64'(r1_in.second_normal_z);
        n2_p[4]  = 64'(r1_in.first_normal_x)  * 64'(r1_in.second_normal_y);
        n2_p[5]  = 64'(r1_in.first_normal_y)  * 64'(r1_in.second_normal_x);
        n2_p[6]  = 64'(r1_in.first_offset)    * 64'(r1_in.second_normal_z);
        n2_p[7]  = 64'(r1_in.second_offset)   * 64'(r1_in.first_normal_z);
        n2_p[8]  = 64'(r1_in.first_normal_y)  * 64'(r1_in.second_offset);
        n2_p[9]  = 64'(r1_in.second_normal_y) * 64'(r1_in.first_offset);
        n2_p[10] = 64'(r1_in.first_normal_x)  * 64'(r1_in.second_offset);
        n2_p[11] = 64'(r1_in.second_normal_x) * 64'(r1_in.first_offset);
        n2_p[12] = 64'(r1_in.first_offset)    * 64'(r1_in.second_normal_y);
        n2_p[13] = 64'(r1_in.second_offset)   * 64'(r1_in.first_normal_y);
    end

    // leading one of the largest magnitude sets the common scale-down
    always_comb begin
        n5_or = r4_m[0] | r4_m[1] | r4_m[2];
        n5_bl = '0;
        for (int i = 0; i < 64; i++) begin
            if (n5_or[i]) n5_bl = 7'(i + 1);
        end
        n5_k = (n5_bl > 7'(NORM_BITS)) ? 6'(n5_bl - 7'(NORM_BITS)) : '0;
        for (int i = 0; i < 3; i++) begin
            n6_mm[i] = 30'(r5_m[i] >> r5_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_in <= i_data;
            for (int i = 0; i < 14; i++) r2_p[i] <= n2_p[i];
            r3_cr[0]     <= r2_p[0] - r2_p[1];
            r3_cr[1]     <= r2_p[2] - r2_p[3];
            r3_cr[2]     <= r2_p[4] - r2_p[5];
            r3_sys.num_a <= r2_p[6] - r2_p[7];
            r3_sys.num_b <= r2_p[8] - r2_p[9];
            r3_sys.num_c <= r2_p[10] - r2_p[11];
            r3_sys.num_d <= r2_p[12] - r2_p[13];
            r3_sys.den_x <= r2_p[0] - r2_p[1];
            r3_sys.den_y <= r2_p[3] - r2_p[2];
            r3_sys.den_z <= r2_p[4] - r2_p[5];
            for (int i = 0; i < 3; i++) begin
                r4_m[i]   <= r3_cr[i][63] ? (~r3_cr[i] + 64'd1) : r3_cr[i];
                r4_neg[i] <= r3_cr[i][63];
                r5_m[i]   <= r4_m[i];
                r5_neg[i] <= r4_neg[i];
                r6_mm[i]  <= n6_mm[i];
                r_lsv[0][i] <= r5_neg[i] ? -t_sv'({1'b0, n6_mm[i]}) : t_sv'({1'b0, n6_mm[i]});
                r7_sq[i]  <= 60'(r6_mm[i]) * 60'(r6_mm[i]);
            end
            r5_k <= n5_k;
            r_la[0].sys <= r3_sys;
            r_la[0].nz  <= (r3_cr[0] != '0) || (r3_cr[1] != '0) || (r3_cr[2] != '0);
            for (int s = 1; s < LA_LEN; s++) r_la[s] <= r_la[s-1];
            for (int s = 1; s < LSV_LEN; s++) r_lsv[s] <= r_lsv[s-1];
        end
    end

    // ---------------- direction length: one root bit per stage ----------------
    logic [61:0] r_isv [0:ISQ_STEPS];
    logic [31:0] r_isr [0:ISQ_STEPS];
    logic [31:0] n_isr [1:ISQ_STEPS];
    logic [31:0] isq_cand;

    always_comb begin
        isq_cand = '0;
        for (int k = 1; k <= ISQ_STEPS; k++) begin
            isq_cand = r_isr[k-1] | (32'd1 << (ISQ_STEPS - k));
            n_isr[k] = ((64'(isq_cand) * 64'(isq_cand)) <= 64'(r_isv[k-1])) ? isq_cand
                                                                            : r_isr[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_isv[0] <= 62'(r7_sq[0]) + 62'(r7_sq[1]) + 62'(r7_sq[2]);
            r_isr[0] <= '0;
            for (int k = 1; k <= ISQ_STEPS; k++) begin
                r_isv[k] <= r_isv[k-1];
                r_isr[k] <= n_isr[k];
            end
        end
    end

    // ---------------- unit direction ----------------
    t_wide len_w;
    t_fix  u_q [0:2];

    assign len_w = t_wide'({32'd0, r_isr[ISQ_STEPS]});

    for (genvar g = 0; g < 3; g++) begin : g_udiv
        pps_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (64'(r_lsv[LSV_LEN-1][g])),
            .i_den (len_w),
            .o_quo (u_q[g])
        );
    end

    // ---------------- axis choice and start point ----------------
    logic [31:0] ux_m, uy_m, uz_m;
    t_axis n_axis;
    t_wide n76_den, n76_n1, n76_n2;
    t_wide r76_den, r76_n1, r76_n2;
    t_ctx_b r_lb [0:LB_LEN-1];
    t_fix  q1, q2;

    assign ux_m = u_q[0][31] ? (~u_q[0] + 32'd1) : u_q[0];
    assign uy_m = u_q[1][31] ? (~u_q[1] + 32'd1) : u_q[1];
    assign uz_m = u_q[2][31] ? (~u_q[2] + 32'd1) : u_q[2];

    // largest component, ties go to the later axis (y over x, z over both)
    always_comb begin
        if (ux_m > uy_m) n_axis = (ux_m > uz_m) ? AXIS_X : AXIS_Z;
        else             n_axis = (uy_m > uz_m) ? AXIS_Y : AXIS_Z;
        case (n_axis)
            AXIS_X: begin
                n76_den = r_la[LA_LEN-1].sys.den_x;
                n76_n1  = r_la[LA_LEN-1].sys.num_a;
                n76_n2  = r_la[LA_LEN-1].sys.num_b;
            end
            AXIS_Y: begin
                n76_den = r_la[LA_LEN-1].sys.den_y;
                n76_n1  = r_la[LA_LEN-1].sys.num_a;
                n76_n2  = r_la[LA_LEN-1].sys.num_c;
            end
            default: begin
                n76_den = r_la[LA_LEN-1].sys.den_z;
                n76_n1  = r_la[LA_LEN-1].sys.num_d;
                n76_n2  = r_la[LA_LEN-1].sys.num_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r76_den     <= n76_den;
            r76_n1      <= n76_n1;
            r76_n2      <= n76_n2;
            r_lb[0].ux  <= u_q[0];
            r_lb[0].uy  <= u_q[1];
            r_lb[0].uz  <= u_q[2];
            r_lb[0].axis <= n_axis;
            r_lb[0].nz  <= r_la[LA_LEN-1].nz;
            for (int s = 1; s < LB_LEN; s++) r_lb[s] <= r_lb[s-1];
        end
    end

    pps_div u_div_p1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r76_n1),
        .i_den (r76_den),
        .o_quo (q1)
    );

    pps_div u_div_p2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r76_n2),
        .i_den (r76_den),
        .o_quo (q2)
    );

    // ---------------- quadratic setup ----------------
    t_fix   p0 [0:2];
    t_fix   ub [0:2];
    t_ctx_c r_lc [0:LC_LEN-1];
    t_wide  r112_pu [0:2];
    t_wide  r112_pp [0:2];
    t_wide  r113_dot, r113_sq, r113_pu2, r113_pp2;
    t_wide  r114_dot, r114_sq;
    logic signed [35:0] r115_c, r116_c;
    t_fix   r_lh [0:LH_LEN-1];
    t_wide  r116_hh;

    // place the two solved coordinates; the chosen axis is zero
    always_comb begin
        ub[0] = r_lb[LB_LEN-1].ux;
        ub[1] = r_lb[LB_LEN-1].uy;
        ub[2] = r_lb[LB_LEN-1].uz;
        case (r_lb[LB_LEN-1].axis)
            AXIS_X: begin
                p0[0] = '0; p0[1] = q1; p0[2] = q2;
            end
            AXIS_Y: begin
                p0[0] = q1; p0[1] = '0; p0[2] = q2;
            end
            default: begin
                p0[0] = q1; p0[1] = q2; p0[2] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r112_pu[i] <= 64'(p0[i]) * 64'(ub[i]);
                r112_pp[i] <= 64'(p0[i]) * 64'(p0[i]);
            end
            r_lc[0].px <= p0[0];
            r_lc[0].py <= p0[1];
            r_lc[0].pz <= p0[2];
            r_lc[0].ux <= ub[0];
            r_lc[0].uy <= ub[1];
            r_lc[0].uz <= ub[2];
            r_lc[0].nz <= r_lb[LB_LEN-1].nz;
            for (int s = 1; s < LC_LEN; s++) r_lc[s] <= r_lc[s-1];
            // clamped dot products, summed in x, y, z order
            r113_dot <= sat_add64(r112_pu[0], r112_pu[1]);
            r113_sq  <= sat_add64(r112_pp[0], r112_pp[1]);
            r113_pu2 <= r112_pu[2];
            r113_pp2 <= r112_pp[2];
            r114_dot <= sat_add64(r113_dot, r113_pu2);
            r114_sq  <= sat_add64(r113_sq, r113_pp2);
            // h and c
            r_lh[0]  <= sat32(68'(r114_dot >>> FRAC));
            r115_c   <= 36'(r114_sq >>> FRAC) - (36'sd1 <<< FRAC);
            for (int s = 1; s < LH_LEN; s++) r_lh[s] <= r_lh[s-1];
            r116_hh  <= 64'(r_lh[0]) * 64'(r_lh[0]);
            r116_c   <= r115_c;
        end
    end

    // ---------------- discriminant root: one bit per stage ----------------
    logic signed [35:0] r_sqd [0:SQ_STEPS];
    logic [30:0] r_sqs [0:SQ_STEPS];
    logic        r_sqok [0:SQ_STEPS];
    logic [30:0] n_sqs [1:SQ_STEPS];
    logic [30:0] sq_cand;
    logic signed [35:0] n_disc;

    assign n_disc = 36'(r116_hh >> FRAC) - r116_c;

    always_comb begin
        sq_cand = '0;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            sq_cand  = r_sqs[k-1] | (31'd1 << (SQ_STEPS - k));
            n_sqs[k] = (((64'(sq_cand) * 64'(sq_cand)) >> FRAC) <= 64'(r_sqd[k-1]))
                       ? sq_cand : r_sqs[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqd[0]  <= n_disc;
            r_sqs[0]  <= '0;
            r_sqok[0] <= n_disc > 36'sd0;
            for (int k = 1; k <= SQ_STEPS; k++) begin
                r_sqd[k]  <= r_sqd[k-1];
                r_sqs[k]  <= n_sqs[k];
                r_sqok[k] <= r_sqok[k-1];
            end
        end
    end

    // ---------------- roots and points ----------------
    logic signed [67:0] hw, sw;
    t_fix  r149_ta, r149_tb;
    logic  r149_ok, r150_ok;
    t_fix  um [0:2];
    t_fix  pf [0:2];
    t_wide r150_pa [0:2];
    t_wide r150_pb [0:2];
    t_out  n_fin, r_fin;

    assign hw = 68'(r_lh[LH_LEN-1]);
    assign sw = {37'd0, r_sqs[SQ_STEPS]};

    assign um[0] = r_lc[LC_LEN-2].ux;
    assign um[1] = r_lc[LC_LEN-2].uy;
    assign um[2] = r_lc[LC_LEN-2].uz;
    assign pf[0] = r_lc[LC_LEN-1].px;
    assign pf[1] = r_lc[LC_LEN-1].py;
    assign pf[2] = r_lc[LC_LEN-1].pz;

    // p0 + u*t, zeroed when there are no two points
    always_comb begin
        n_fin.found    = r150_ok && r_lc[LC_LEN-1].nz;
        n_fin.first_x  = sat32(68'(pf[0]) + 68'(r150_pa[0] >>> FRAC));
        n_fin.first_y  = sat32(68'(pf[1]) + 68'(r150_pa[1] >>> FRAC));
        n_fin.first_z  = sat32(68'(pf[2]) + 68'(r150_pa[2] >>> FRAC));
        n_fin.second_x = sat32(68'(pf[0]) + 68'(r150_pb[0] >>> FRAC));
        n_fin.second_y = sat32(68'(pf[1]) + 68'(r150_pb[1] >>> FRAC));
        n_fin.second_z = sat32(68'(pf[2]) + 68'(r150_pb[2] >>> FRAC));
        if (!n_fin.found) begin
            n_fin = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r149_ta <= sat32(sw - hw);
            r149_tb <= sat32(-hw - sw);
            r149_ok <= r_sqok[SQ_STEPS];
            for (int i = 0; i < 3; i++) begin
                r150_pa[i] <= 64'(um[i]) * 64'(r149_ta);
                r150_pb[i] <= 64'(um[i]) * 64'(r149_tb);
            end
            r150_ok <= r149_ok;
            r_fin   <= n_fin;
        end
        if (load) r_out <= r_fin;
    end

    // ---------------- checks ----------------
    `PPS_CHECK_NOW(a_stall_only_when_full, o_stall, o_valid && i_stall && r_vld[PIPE_LAT-1])
    `PPS_CHECK_NOW(a_miss_points_zero, o_valid && !o_data.found, o_data.first_x == '0 && o_data.first_y == '0 && o_data.first_z == '0 && o_data.second_x == '0 && o_data.second_y == '0 && o_data.second_z == '0)
    `PPS_CHECK_NEXT(a_last_stage_moves_out, r_vld[PIPE_LAT-1] && !o_stall, o_valid)

endmodule

@@ rtl/core/pps_div.sv @@
// Pipelined signed fixed point divider: trunc(num * 2^FRAC / den), clamped to 32 bits
module pps_div
    import pps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_wide i_num,
    input  t_wide i_den,
    output t_fix  o_quo
);

    logic [63:0] n_un, n_ud;
    logic [63:0] r_un, r_ud;
    logic        r_neg, r_dz, r_nz, r_npos;
    t_div_st     n_st [0:DIV_BITS];
    t_div_st     r_st [0:DIV_BITS];
    logic [DIV_W-1:0] dvs;
    logic        lim;
    t_fix        n_quo, r_quo;

    // magnitudes
    assign n_un = i_num[63] ? (~i_num + 64'd1) : i_num;
    assign n_ud = i_den[63] ? (~i_den + 64'd1) : i_den;

    // set up the remainder and the overflow test, then one quotient bit per stage
    always_comb begin
        n_st[0].rem  = DIV_W'(r_un) << FRAC;
        n_st[0].ud   = r_ud;
        n_st[0].q    = '0;
        n_st[0].neg  = r_neg;
        n_st[0].dz   = r_dz;
        n_st[0].nz   = r_nz;
        n_st[0].npos = r_npos;
        n_st[0].ovf  = (DIV_W'(r_un) << FRAC) >= (DIV_W'(r_ud) << DIV_BITS);
        dvs = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            dvs = DIV_W'(r_st[k].ud) << (DIV_BITS - 1 - k);
            n_st[k+1] = r_st[k];
            if (r_st[k].rem >= dvs) begin
                n_st[k+1].rem = r_st[k].rem - dvs;
                n_st[k+1].q[DIV_BITS-1-k] = 1'b1;
            end
        end
    end

    // sign, zero divisor and clamp
    always_comb begin
        lim = r_st[DIV_BITS].q[31] && (!r_st[DIV_BITS].neg || (|r_st[DIV_BITS].q[30:0]));
        if (r_st[DIV_BITS].dz) begin
            if (r_st[DIV_BITS].nz) n_quo = '0;
            else                   n_quo = r_st[DIV_BITS].npos ? FIX_MAX : FIX_MIN;
        end else if (r_st[DIV_BITS].ovf || lim) begin
            n_quo = r_st[DIV_BITS].neg ? FIX_MIN : FIX_MAX;
        end else begin
            n_quo = r_st[DIV_BITS].neg ? t_fix'(32'd0 - r_st[DIV_BITS].q)
                                       : t_fix'(r_st[DIV_BITS].q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_un   <= n_un;
            r_ud   <= n_ud;
            r_neg  <= i_num[63] ^ i_den[63];
            r_dz   <= (i_den == '0);
            r_nz   <= (i_num == '0);
            r_npos <= !i_num[63] && (i_num != '0);
            for (int k = 0; k <= DIV_BITS; k++) begin
                r_st[k] <= n_st[k];
            end
            r_quo  <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule
